@@ hdl/bdhc_pkg.sv @@
// ----------------------------------------------------------------------------
// bdhc_pkg
// Shared types and constants for the button debounce and hold classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package bdhc_pkg;

    // Default structural widths
    localparam int ELAPSED_BITS_DEF  = 16;
    localparam int DEBOUNCE_BITS_DEF = 8;

    // Field widths fixed by the interface
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int HELD_W     = 16;
    localparam int CLASS_W    = 3;
    localparam int DBC_CFG_W  = 8;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 24;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VLONG    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VVLONG   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESSED  = 3'd5;

    // Configuration reset values
    localparam logic [DBC_CFG_W-1:0] RST_DEBOUNCE = 8'd20;
    localparam logic [HELD_W-1:0]    RST_SHORT    = 16'd500;
    localparam logic [HELD_W-1:0]    RST_LONG     = 16'd1000;
    localparam logic [HELD_W-1:0]    RST_VLONG    = 16'd3000;
    localparam logic [HELD_W-1:0]    RST_VVLONG   = 16'd10000;
    localparam logic                 RST_PRESSED  = 1'b0;

    // Hold classes
    localparam logic [CLASS_W-1:0] CLS_SHORT  = 3'd0;
    localparam logic [CLASS_W-1:0] CLS_LONG   = 3'd1;
    localparam logic [CLASS_W-1:0] CLS_VLONG  = 3'd2;
    localparam logic [CLASS_W-1:0] CLS_VVLONG = 3'd3;
    localparam logic [CLASS_W-1:0] CLS_OVER   = 3'd4;

    // Hold thresholds
    typedef struct packed {
        logic [HELD_W-1:0] short_ms;
        logic [HELD_W-1:0] long_ms;
        logic [HELD_W-1:0] vlong_ms;
        logic [HELD_W-1:0] vvlong_ms;
    } t_limits;

    // Event from the tracker to the output stage
    typedef struct packed {
        logic              fire;      // a word is produced this step
        logic              is_press;
        logic              held_over; // elapsed count beyond 16 bits
        logic [HELD_W-1:0] held_ms;   // saturated to 16 bits
    } t_event;

endpackage

`default_nettype wire

@@ hdl/bdhc_tracker.sv @@
// ----------------------------------------------------------------------------
// bdhc_tracker
// Edge detection, debounce countdown, level judgement and elapsed counter.
// ----------------------------------------------------------------------------
`default_nettype none

module bdhc_tracker #(
    parameter int ELAPSED_BITS  = bdhc_pkg::ELAPSED_BITS_DEF,
    parameter int DEBOUNCE_BITS = bdhc_pkg::DEBOUNCE_BITS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_step,
    input  wire                                i_pin_level,
    input  wire  [bdhc_pkg::DBC_CFG_W-1:0]     i_debounce_ms,
    input  wire                                i_pressed_level,
    output bdhc_pkg::t_event                   o_event
);
    import bdhc_pkg::*;

    localparam logic [ELAPSED_BITS-1:0]  ELAPSED_MAX  = {ELAPSED_BITS{1'b1}};
    localparam logic [DEBOUNCE_BITS-1:0] DEBOUNCE_MAX = {DEBOUNCE_BITS{1'b1}};

    logic                     r_prev,    n_prev;
    logic                     r_pending, n_pending;
    logic                     r_capt,    n_capt;
    logic [DEBOUNCE_BITS-1:0] r_left,    n_left;
    logic [ELAPSED_BITS-1:0]  r_elapsed, n_elapsed;
    logic                     r_btn,     n_btn;

    logic [ELAPSED_BITS-1:0]  elapsed_inc;
    logic [31:0]              elapsed_w;
    logic [CFG_DATA_W-1:0]    dbc_req;
    logic [CFG_DATA_W-1:0]    dbc_lim;
    logic [DEBOUNCE_BITS-1:0] dbc_load;
    t_event                   ev;

    // Saturating tick count including this tick
    assign elapsed_inc = (r_elapsed < ELAPSED_MAX) ? r_elapsed + 1'b1 : r_elapsed;
    assign elapsed_w   = 32'(elapsed_inc);

    // Countdown length: clamp to counter range, zero acts as one
    always_comb begin
        dbc_req = CFG_DATA_W'(i_debounce_ms);
        dbc_lim = (dbc_req > CFG_DATA_W'(DEBOUNCE_MAX)) ? CFG_DATA_W'(DEBOUNCE_MAX) : dbc_req;
        if (dbc_lim == '0) begin
            dbc_lim = CFG_DATA_W'(1);
        end
        dbc_load = DEBOUNCE_BITS'(dbc_lim);
    end

    // Judgement then edge detection
    always_comb begin
        n_prev    = i_pin_level;
        n_pending = r_pending;
        n_capt    = r_capt;
        n_left    = r_left;
        n_elapsed = elapsed_inc;
        n_btn     = r_btn;

        ev.fire      = 1'b0;
        ev.is_press  = 1'b0;
        ev.held_over = (elapsed_w > 32'h0000_FFFF);
        ev.held_ms   = ev.held_over ? {HELD_W{1'b1}} : elapsed_w[HELD_W-1:0];

        if (r_pending) begin
            if (r_left <= DEBOUNCE_BITS'(1)) begin
                n_pending = 1'b0;
                n_left    = '0;
                if (i_pin_level == r_capt) begin
                    n_elapsed = '0;
                    if (i_pin_level == i_pressed_level) begin
                        n_btn       = 1'b1;
                        ev.fire     = 1'b1;
                        ev.is_press = 1'b1;
                    end else begin
                        ev.fire = r_btn;
                        n_btn   = 1'b0;
                    end
                end
            end else begin
                n_left = r_left - 1'b1;
            end
        end

        if ((i_pin_level != r_prev) && !n_pending) begin
            n_pending = 1'b1;
            n_capt    = i_pin_level;
            n_left    = dbc_load;
        end
    end

    assign o_event = ev;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev    <= ~RST_PRESSED;
            r_pending <= 1'b0;
            r_capt    <= 1'b0;
            r_left    <= '0;
            r_elapsed <= '0;
            r_btn     <= 1'b0;
        end else if (i_step) begin
            r_prev    <= n_prev;
            r_pending <= n_pending;
            r_capt    <= n_capt;
            r_left    <= n_left;
            r_elapsed <= n_elapsed;
            r_btn     <= n_btn;
        end
    end

    // Countdown is live exactly while a check is pending
    a_pending_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending |-> (r_left != '0))
        else $error("pending check with empty countdown");

    a_idle_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_pending |-> (r_left == '0))
        else $error("countdown running without a pending check");

    // A release word only follows a recorded press
    a_release_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && ev.fire && !ev.is_press) |-> r_btn)
        else $error("release word without a press");

endmodule

`default_nettype wire

@@ hdl/bdhc_out.sv @@
// ----------------------------------------------------------------------------
// bdhc_out
// Hold classification and output register for result words.
// ----------------------------------------------------------------------------
`default_nettype none

module bdhc_out (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_step,
    input  bdhc_pkg::t_event                   i_event,
    input  bdhc_pkg::t_limits                  i_limits,
    output logic                               o_free,
    output logic                               o_m_tvalid,
    input  wire                                i_m_tready,
    output logic [bdhc_pkg::M_TDATA_W-1:0]     o_m_tdata,
    output logic                               o_m_tuser
);
    import bdhc_pkg::*;

    logic               r_valid;
    logic               r_press;
    logic [CLASS_W-1:0] r_class, n_class;
    logic [HELD_W-1:0]  r_held;

    // Threshold ladder; a press always reports class zero
    always_comb begin
        if (i_event.is_press) begin
            n_class = CLS_SHORT;
        end else if (i_event.held_over) begin
            n_class = CLS_OVER;
        end else if (i_event.held_ms < i_limits.short_ms) begin
            n_class = CLS_SHORT;
        end else if (i_event.held_ms < i_limits.long_ms) begin
            n_class = CLS_LONG;
        end else if (i_event.held_ms < i_limits.vlong_ms) begin
            n_class = CLS_VLONG;
        end else if (i_event.held_ms < i_limits.vvlong_ms) begin
            n_class = CLS_VVLONG;
        end else begin
            n_class = CLS_OVER;
        end
    end

    // Free when empty or being drained this cycle
    assign o_free = !r_valid || i_m_tready;

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_step && i_event.fire) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_step && i_event.fire) begin
            r_press <= i_event.is_press;
            r_class <= n_class;
            r_held  <= i_event.held_ms;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tuser  = r_press;
    assign o_m_tdata  = {{(M_TDATA_W - CLASS_W - HELD_W){1'b0}}, r_held, r_class};

    // Presses carry class zero, releases stay within the ladder
    a_press_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_press) |-> (r_class == CLS_SHORT))
        else $error("press word with nonzero class");

    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_class <= CLS_OVER))
        else $error("hold class out of range");

    // No word is overwritten while still waiting
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_m_tready) |-> !(i_step && i_event.fire))
        else $error("result word overwritten");

endmodule

`default_nettype wire

@@ hdl/button_debounce_hold_classifier.sv @@
// Result words are registered and reach the master side the cycle after their input is taken.
// Throughput: one pin sample per cycle; the only stall is a held result word not yet taken.
// The output register lets a new sample in while the result is drained in the same cycle.
// Reset (synchronous, active low): registers to their defaults, debounce idle, counter zero.
// The last level resets to the released level; no result word pending.
// ----------------------------------------------------------------------------
// button_debounce_hold_classifier
// Debounces a sampled button level and reports press and release words with
// the hold time and its duration class.
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_hold_classifier #(
    parameter int ELAPSED_BITS  = bdhc_pkg::ELAPSED_BITS_DEF,
    parameter int DEBOUNCE_BITS = bdhc_pkg::DEBOUNCE_BITS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // Configuration write port
    input  wire                                i_cfg_we,
    input  wire  [bdhc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire  [bdhc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // Slave side
    input  wire                                i_s_tvalid,
    output logic                               o_s_tready,
    input  wire  [bdhc_pkg::S_TDATA_W-1:0]     i_s_tdata,  // [0] pin_level
    // Master side
    output logic                               o_m_tvalid,
    input  wire                                i_m_tready,
    output logic [bdhc_pkg::M_TDATA_W-1:0]     o_m_tdata,  // [2:0] hold_class, [18:3] held_ms
    output logic                               o_m_tuser   // [0] is_press
);
    import bdhc_pkg::*;

    logic [DBC_CFG_W-1:0] r_debounce;
    t_limits              r_limits;
    logic                 r_pressed;

    logic                 step;
    logic                 out_free;
    t_event               ev;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce         <= RST_DEBOUNCE;
            r_limits.short_ms  <= RST_SHORT;
            r_limits.long_ms   <= RST_LONG;
            r_limits.vlong_ms  <= RST_VLONG;
            r_limits.vvlong_ms <= RST_VVLONG;
            r_pressed          <= RST_PRESSED;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEBOUNCE: r_debounce         <= i_cfg_data[DBC_CFG_W-1:0];
                CFG_SHORT:    r_limits.short_ms  <= i_cfg_data;
                CFG_LONG:     r_limits.long_ms   <= i_cfg_data;
                CFG_VLONG:    r_limits.vlong_ms  <= i_cfg_data;
                CFG_VVLONG:   r_limits.vvlong_ms <= i_cfg_data;
                CFG_PRESSED:  r_pressed          <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Input handshake
    assign o_s_tready = out_free;
    assign step       = i_s_tvalid && out_free;

    bdhc_tracker #(
        .ELAPSED_BITS  (ELAPSED_BITS),
        .DEBOUNCE_BITS (DEBOUNCE_BITS)
    ) u_tracker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (step),
        .i_pin_level     (i_s_tdata[0]),
        .i_debounce_ms   (r_debounce),
        .i_pressed_level (r_pressed),
        .o_event         (ev)
    );

    bdhc_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_event    (ev),
        .i_limits   (r_limits),
        .o_free     (out_free),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

`default_nettype wire
